// File: src/fbpa_pkg.sv
// Shared types and constants for the fixed block pool allocator.
package fbpa_pkg;

  localparam int MAX_BLOCKS_DEF  = 256;
  localparam int OFFSET_BITS_DEF = 20;

  localparam int SIZE_W  = 13;
  localparam int COUNT_W = 9;
  localparam int REQ_W   = 20;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  localparam int BLOCK_SIZE_RST  = 64;
  localparam int BLOCK_COUNT_RST = 256;

  localparam int QUEUE_DEPTH = 2;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_BLOCK_SIZE  = 2'd0,
    REG_BLOCK_COUNT = 2'd1
  } reg_idx_t;

  typedef enum logic [2:0] {
    ST_OK         = 3'd0,
    ST_TOO_LARGE  = 3'd1,
    ST_EMPTY      = 3'd2,
    ST_RANGE      = 3'd3,
    ST_MISALIGNED = 3'd4,
    ST_NULL       = 3'd5,
    ST_FULL       = 3'd6
  } status_t;

  typedef enum logic [1:0] {
    CMD_ALLOC  = 2'd0,
    CMD_FREE   = 2'd1,
    CMD_REPORT = 2'd2
  } cmd_t;

  // work handed from the front to the back
  typedef struct packed {
    cmd_t    cmd;
    status_t status;
  } qcmd_t;

  // free list condition seen by the top level
  typedef struct packed {
    logic list_empty;
    logic list_full;
  } bk_stat_t;

endpackage

// File: src/fbpa_if.sv
// Channel interfaces: request, result and configuration write.
interface fbpa_in_if import fbpa_pkg::*; #(
  parameter int OFFSET_BITS = OFFSET_BITS_DEF
) ();
  logic                   valid;
  logic                   ready;
  logic                   kind;
  logic [REQ_W-1:0]       request_size;
  logic [OFFSET_BITS-1:0] release_offset;
  logic                   release_null;

  modport source (output valid, kind, request_size, release_offset, release_null,
                  input ready);
  modport sink   (input valid, kind, request_size, release_offset, release_null,
                  output ready);
endinterface

interface fbpa_out_if import fbpa_pkg::*; #(
  parameter int OFFSET_BITS = OFFSET_BITS_DEF
) ();
  logic                   valid;
  logic                   ready;
  status_t                status;
  logic [OFFSET_BITS-1:0] block_offset;

  modport source (output valid, status, block_offset, input ready);
  modport sink   (input valid, status, block_offset, output ready);
endinterface

interface fbpa_cfg_if import fbpa_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// File: src/fbpa_front.sv
// Front end: takes request beats, runs the stateless checks and the offset divide.
module fbpa_front import fbpa_pkg::*; #(
  parameter  int MAX_BLOCKS  = MAX_BLOCKS_DEF,
  parameter  int OFFSET_BITS = OFFSET_BITS_DEF,
  localparam int IDX_W       = $clog2(MAX_BLOCKS),
  localparam int CNT_W       = $clog2(MAX_BLOCKS + 1),
  localparam int PB_W        = SIZE_W + CNT_W
) (
  input  logic              clk,
  input  logic              rst_n,
  fbpa_in_if.sink           in_ch,
  input  logic [SIZE_W-1:0] block_size,
  input  logic [PB_W-1:0]   pool_bytes,
  output logic              push_valid,
  input  logic              push_ready,
  output qcmd_t             push_cmd,
  output logic [IDX_W-1:0]  push_idx
);

  localparam int DC_W  = $clog2(OFFSET_BITS);
  localparam int CMP_W = PB_W + OFFSET_BITS;

  typedef enum logic [3:0] {
    F_IDLE  = 4'b0001,
    F_CHECK = 4'b0010,
    F_DIV   = 4'b0100,
    F_PUSH  = 4'b1000
  } front_state_t;

  front_state_t state_r, state_nxt;

  logic                   kind_r;
  logic [REQ_W-1:0]       req_r;
  logic [OFFSET_BITS-1:0] off_r;
  logic                   null_r;

  qcmd_t                  entry_r, entry_nxt;
  logic [IDX_W-1:0]       idx_r, idx_nxt;
  logic [SIZE_W-1:0]      rem_r, rem_nxt;
  logic [OFFSET_BITS-1:0] dvd_r, dvd_nxt;
  logic [DC_W-1:0]        cnt_r, cnt_nxt;

  logic [SIZE_W:0]          rem_sh;
  logic [SIZE_W:0]          divisor;
  logic                     sub_ok;
  logic [SIZE_W-1:0]        rem_step;
  logic [OFFSET_BITS-1:0]   quo_step;
  logic [IDX_W+OFFSET_BITS-1:0] quo_ext;
  logic [CMP_W-1:0]         off_ext;
  logic [CMP_W-1:0]         pb_ext;
  logic                     too_large;
  logic                     accept;

  assign in_ch.ready = (state_r == F_IDLE);
  assign accept      = in_ch.valid && in_ch.ready;

  assign push_valid = (state_r == F_PUSH);
  assign push_cmd   = entry_r;
  assign push_idx   = idx_r;

  // one restoring divide step per cycle, quotient shifts in behind the dividend
  assign divisor  = {1'b0, block_size};
  assign rem_sh   = {rem_r, dvd_r[OFFSET_BITS-1]};
  assign sub_ok   = (rem_sh >= divisor);
  assign rem_step = sub_ok ? SIZE_W'(rem_sh - divisor) : rem_sh[SIZE_W-1:0];
  assign quo_step = {dvd_r[OFFSET_BITS-2:0], sub_ok};
  assign quo_ext  = {{IDX_W{1'b0}}, quo_step};

  assign off_ext   = {{PB_W{1'b0}}, off_r};
  assign pb_ext    = {{OFFSET_BITS{1'b0}}, pool_bytes};
  assign too_large = (req_r > REQ_W'(block_size)) && (block_size != '0);

  always_comb begin
    state_nxt = state_r;
    entry_nxt = entry_r;
    idx_nxt   = idx_r;
    rem_nxt   = rem_r;
    dvd_nxt   = dvd_r;
    cnt_nxt   = cnt_r;
    unique case (state_r)
      F_IDLE: begin
        if (accept) state_nxt = F_CHECK;
      end
      F_CHECK: begin
        idx_nxt   = '0;
        state_nxt = F_PUSH;
        if (!kind_r) begin
          entry_nxt.cmd    = too_large ? CMD_REPORT : CMD_ALLOC;
          entry_nxt.status = too_large ? ST_TOO_LARGE : ST_OK;
        end else if (null_r) begin
          entry_nxt.cmd    = CMD_REPORT;
          entry_nxt.status = ST_NULL;
        end else if (off_ext >= pb_ext) begin
          entry_nxt.cmd    = CMD_REPORT;
          entry_nxt.status = ST_RANGE;
        end else begin
          rem_nxt   = '0;
          dvd_nxt   = off_r;
          cnt_nxt   = '0;
          state_nxt = F_DIV;
        end
      end
      F_DIV: begin
        rem_nxt = rem_step;
        dvd_nxt = quo_step;
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == DC_W'(OFFSET_BITS - 1)) begin
          if (rem_step != '0) begin
            entry_nxt.cmd    = CMD_REPORT;
            entry_nxt.status = ST_MISALIGNED;
          end else begin
            entry_nxt.cmd    = CMD_FREE;
            entry_nxt.status = ST_OK;
          end
          idx_nxt   = quo_ext[IDX_W-1:0];
          state_nxt = F_PUSH;
        end
      end
      F_PUSH: begin
        if (push_ready) state_nxt = F_IDLE;
      end
      default: state_nxt = F_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= F_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      kind_r <= in_ch.kind;
      req_r  <= in_ch.request_size;
      off_r  <= in_ch.release_offset;
      null_r <= in_ch.release_null;
    end
    entry_r <= entry_nxt;
    idx_r   <= idx_nxt;
    rem_r   <= rem_nxt;
    dvd_r   <= dvd_nxt;
    cnt_r   <= cnt_nxt;
  end

endmodule

// File: src/fbpa_queue.sv
// Short command queue between the front end and the free list back end.
module fbpa_queue import fbpa_pkg::*; #(
  parameter int IDX_W = 8
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push_valid,
  output logic             push_ready,
  input  qcmd_t            push_cmd,
  input  logic [IDX_W-1:0] push_idx,
  output logic             pop_valid,
  input  logic             pop_ready,
  output qcmd_t            pop_cmd,
  output logic [IDX_W-1:0] pop_idx
);

  localparam int QP_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QC_W = $clog2(QUEUE_DEPTH + 1);

  qcmd_t            cmd_q [QUEUE_DEPTH];
  logic [IDX_W-1:0] idx_q [QUEUE_DEPTH];

  logic [QP_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QP_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [QC_W-1:0] count_r, count_nxt;
  logic            do_push, do_pop;

  assign push_ready = (count_r != QC_W'(QUEUE_DEPTH));
  assign pop_valid  = (count_r != '0);
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;
  assign pop_cmd    = cmd_q[rd_ptr_r];
  assign pop_idx    = idx_q[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == QP_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == QP_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      cmd_q[wr_ptr_r] <= push_cmd;
      idx_q[wr_ptr_r] <= push_idx;
    end
  end

endmodule

// File: src/fbpa_back.sv
// Back end: FIFO free list, pop and push, offset multiply and result register.
module fbpa_back import fbpa_pkg::*; #(
  parameter  int MAX_BLOCKS  = MAX_BLOCKS_DEF,
  parameter  int OFFSET_BITS = OFFSET_BITS_DEF,
  localparam int IDX_W       = $clog2(MAX_BLOCKS),
  localparam int CNT_W       = $clog2(MAX_BLOCKS + 1)
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic [SIZE_W-1:0] block_size,
  input  logic [CNT_W-1:0]  eff_count,
  input  logic              refill,
  input  logic              pop_valid,
  output logic              pop_ready,
  input  qcmd_t             pop_cmd,
  input  logic [IDX_W-1:0]  pop_idx,
  output bk_stat_t          stat,
  fbpa_out_if.source        out_ch
);

  localparam int DW     = CNT_W + 1;
  localparam int PROD_W = IDX_W + SIZE_W;
  localparam int RST_N  = (BLOCK_COUNT_RST > MAX_BLOCKS) ? MAX_BLOCKS : BLOCK_COUNT_RST;
  localparam int RST_T  = (RST_N == MAX_BLOCKS) ? 0 : RST_N;

  typedef enum logic [3:0] {
    B_IDLE = 4'b0001,
    B_READ = 4'b0010,
    B_MUL  = 4'b0100,
    B_OUT  = 4'b1000
  } back_state_t;

  back_state_t state_r, state_nxt;

  logic [IDX_W-1:0] mem [MAX_BLOCKS];

  logic [IDX_W-1:0] head_r, head_nxt;
  logic [IDX_W-1:0] tail_r, tail_nxt;
  logic [CNT_W-1:0] free_cnt_r, free_cnt_nxt;
  logic [CNT_W-1:0] pushed_r, pushed_nxt;

  logic [IDX_W-1:0]       rd_data_r;
  logic [IDX_W-1:0]       rd_addr_r;
  logic                   written_r;
  status_t                res_status_r, res_status_nxt;
  logic [OFFSET_BITS-1:0] res_off_r, res_off_nxt;

  logic                   out_valid_r;
  status_t                out_status_r;
  logic [OFFSET_BITS-1:0] out_off_r;

  logic mem_re, mem_we, load_out;
  logic [DW-1:0] head_w, n_w, wr_dist;
  logic written;
  logic [IDX_W-1:0] idx_sel;
  logic [PROD_W-1:0] prod;
  logic [PROD_W+OFFSET_BITS-1:0] prod_ext;
  logic list_full;

  assign pop_ready = (state_r == B_IDLE);
  assign list_full = (free_cnt_r == CNT_W'(MAX_BLOCKS));
  assign stat.list_empty = (free_cnt_r == '0);
  assign stat.list_full  = list_full;

  // entries not yet overwritten since the last fill still hold their own index;
  // pushes land at positions n, n+1, ... so the written span is tracked by count
  assign head_w  = DW'(head_r);
  assign n_w     = DW'(eff_count);
  assign wr_dist = (head_w >= n_w) ? head_w - n_w : head_w + DW'(MAX_BLOCKS) - n_w;
  assign written = (wr_dist < DW'(pushed_r));

  assign idx_sel  = written_r ? rd_data_r : rd_addr_r;
  assign prod     = PROD_W'(idx_sel) * PROD_W'(block_size);
  assign prod_ext = {{OFFSET_BITS{1'b0}}, prod};

  assign load_out = (state_r == B_OUT) && (!out_valid_r || out_ch.ready);

  assign out_ch.valid        = out_valid_r;
  assign out_ch.status       = out_status_r;
  assign out_ch.block_offset = out_off_r;

  always_comb begin
    state_nxt      = state_r;
    head_nxt       = head_r;
    tail_nxt       = tail_r;
    free_cnt_nxt   = free_cnt_r;
    pushed_nxt     = pushed_r;
    res_status_nxt = res_status_r;
    res_off_nxt    = res_off_r;
    mem_re         = 1'b0;
    mem_we         = 1'b0;
    unique case (state_r)
      B_IDLE: begin
        if (pop_valid) begin
          res_off_nxt = '0;
          state_nxt   = B_OUT;
          unique case (pop_cmd.cmd)
            CMD_ALLOC: begin
              if (free_cnt_r == '0) begin
                res_status_nxt = ST_EMPTY;
              end else begin
                mem_re         = 1'b1;
                head_nxt       = (head_r == IDX_W'(MAX_BLOCKS - 1)) ? '0 : head_r + 1'b1;
                free_cnt_nxt   = free_cnt_r - 1'b1;
                res_status_nxt = ST_OK;
                state_nxt      = B_READ;
              end
            end
            CMD_FREE: begin
              if (list_full) begin
                res_status_nxt = ST_FULL;
              end else begin
                mem_we         = 1'b1;
                tail_nxt       = (tail_r == IDX_W'(MAX_BLOCKS - 1)) ? '0 : tail_r + 1'b1;
                free_cnt_nxt   = free_cnt_r + 1'b1;
                pushed_nxt     = (pushed_r == CNT_W'(MAX_BLOCKS)) ? pushed_r
                                                                  : pushed_r + 1'b1;
                res_status_nxt = ST_OK;
              end
            end
            default: res_status_nxt = pop_cmd.status;
          endcase
        end
      end
      B_READ: state_nxt = B_MUL;
      B_MUL: begin
        res_off_nxt = prod_ext[OFFSET_BITS-1:0];
        state_nxt   = B_OUT;
      end
      B_OUT: begin
        if (load_out) state_nxt = B_IDLE;
      end
      default: state_nxt = B_IDLE;
    endcase
    if (refill) begin
      head_nxt     = '0;
      tail_nxt     = (eff_count == CNT_W'(MAX_BLOCKS)) ? '0 : IDX_W'(eff_count);
      free_cnt_nxt = eff_count;
      pushed_nxt   = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= B_IDLE;
      head_r      <= '0;
      tail_r      <= IDX_W'(RST_T);
      free_cnt_r  <= CNT_W'(RST_N);
      pushed_r    <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      head_r     <= head_nxt;
      tail_r     <= tail_nxt;
      free_cnt_r <= free_cnt_nxt;
      pushed_r   <= pushed_nxt;
      if (load_out) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[tail_r] <= pop_idx;
    end
    if (mem_re) begin
      rd_data_r <= mem[head_r];
    end
  end

  always_ff @(posedge clk) begin
    if (mem_re) begin
      rd_addr_r <= head_r;
      written_r <= written;
    end
    res_status_r <= res_status_nxt;
    res_off_r    <= res_off_nxt;
    if (load_out) begin
      out_status_r <= res_status_r;
      out_off_r    <= res_off_r;
    end
  end

endmodule

// File: src/fixed_block_pool_allocator.sv
// Fixed block pool allocator: one status beat per request, allocate pops a FIFO free list,
// release pushes a checked block index back. A release runs through the radix-2 divider in
// the front end, which works out the block index and alignment one bit per cycle. A short
// queue separates the front end from the free list, so a new request can be checked while
// the previous one is still in the back end or its result waits on the output register.
// The free list needs no clearing pass: a block_count write (or reset) restarts it at once,
// entries not yet written since then read back as their own index.
module fixed_block_pool_allocator import fbpa_pkg::*; #(
  parameter int MAX_BLOCKS  = MAX_BLOCKS_DEF,
  parameter int OFFSET_BITS = OFFSET_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  fbpa_in_if.sink     in_ch,
  fbpa_out_if.source  out_ch,
  fbpa_cfg_if.sink    cfg_ch
);

  localparam int IDX_W = $clog2(MAX_BLOCKS);
  localparam int CNT_W = $clog2(MAX_BLOCKS + 1);
  localparam int PB_W  = SIZE_W + CNT_W;

  logic [SIZE_W-1:0]  block_size_r;
  logic [COUNT_W-1:0] block_count_r;
  logic               refill_r;
  logic [CNT_W-1:0]   eff_count;
  logic [PB_W-1:0]    pool_bytes_r;
  logic               cfg_we;

  logic             f_push_valid, f_push_ready;
  qcmd_t            f_push_cmd;
  logic [IDX_W-1:0] f_push_idx;
  logic             q_pop_valid, q_pop_ready;
  qcmd_t            q_pop_cmd;
  logic [IDX_W-1:0] q_pop_idx;
  bk_stat_t         bk_stat;

  assign cfg_ch.ready = 1'b1;
  assign cfg_we       = cfg_ch.valid && cfg_ch.ready;

  assign eff_count = (32'(block_count_r) > MAX_BLOCKS) ? CNT_W'(MAX_BLOCKS)
                                                       : CNT_W'(block_count_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      block_size_r  <= SIZE_W'(BLOCK_SIZE_RST);
      block_count_r <= COUNT_W'(BLOCK_COUNT_RST);
      refill_r      <= 1'b0;
    end else begin
      refill_r <= 1'b0;
      if (cfg_we) begin
        case (cfg_ch.index)
          REG_BLOCK_SIZE:  block_size_r <= cfg_ch.data[SIZE_W-1:0];
          REG_BLOCK_COUNT: begin
            block_count_r <= cfg_ch.data[COUNT_W-1:0];
            refill_r      <= 1'b1;
          end
          default: ;
        endcase
      end
    end
  end

  // pool size only moves with configuration, so a registered product is enough
  always_ff @(posedge clk) begin
    pool_bytes_r <= PB_W'(block_size_r) * PB_W'(eff_count);
  end

  fbpa_front #(
    .MAX_BLOCKS  (MAX_BLOCKS),
    .OFFSET_BITS (OFFSET_BITS)
  ) u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_ch      (in_ch),
    .block_size (block_size_r),
    .pool_bytes (pool_bytes_r),
    .push_valid (f_push_valid),
    .push_ready (f_push_ready),
    .push_cmd   (f_push_cmd),
    .push_idx   (f_push_idx)
  );

  fbpa_queue #(
    .IDX_W (IDX_W)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (f_push_valid),
    .push_ready (f_push_ready),
    .push_cmd   (f_push_cmd),
    .push_idx   (f_push_idx),
    .pop_valid  (q_pop_valid),
    .pop_ready  (q_pop_ready),
    .pop_cmd    (q_pop_cmd),
    .pop_idx    (q_pop_idx)
  );

  fbpa_back #(
    .MAX_BLOCKS  (MAX_BLOCKS),
    .OFFSET_BITS (OFFSET_BITS)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .block_size (block_size_r),
    .eff_count  (eff_count),
    .refill     (refill_r),
    .pop_valid  (q_pop_valid),
    .pop_ready  (q_pop_ready),
    .pop_cmd    (q_pop_cmd),
    .pop_idx    (q_pop_idx),
    .stat       (bk_stat),
    .out_ch     (out_ch)
  );

`ifndef SYNTHESIS
  // only a successful allocate carries an offset
  a_offset_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && out_ch.status != ST_OK |-> out_ch.block_offset == '0)
    else $error("nonzero offset on a failed or release beat");

  // a refill with a nonzero count leaves blocks to hand out
  a_refill_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    $past(refill_r) && eff_count != '0 |-> !bk_stat.list_empty)
    else $error("free list empty after refill");

  a_empty_full: assert property (@(posedge clk) disable iff (!rst_n)
    !(bk_stat.list_empty && bk_stat.list_full))
    else $error("free list both empty and full");

  // the front end holds one request at a time
  a_front_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_ch.valid && in_ch.ready |=> !in_ch.ready)
    else $error("request beat taken while front end busy");
`endif

endmodule
